### hw/rtl/c3ws_pkg.sv
// shared types and constants of the 3x3 weighted convolution block
`timescale 1ns / 1ps
`default_nettype none

package c3ws_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHTS_TOP    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHTS_MIDDLE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHTS_BOTTOM = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT  = 3'd5;

   localparam logic [12:0] FRAME_WIDTH_RST   = 13'd640;
   localparam logic [12:0] FRAME_HEIGHT_RST  = 13'd480;
   localparam logic [2:0]  CHANNEL_COUNT_RST = 3'd1;
   localparam logic [12:0] FRAME_HEIGHT_MAX  = 13'd4096;

   localparam int ROW_W = 16;
   localparam logic [ROW_W-1:0] ROW_CAP = 16'hFFFF;
   localparam int COUNT_W = 29;

   localparam int PROD_W = 17;
   localparam int SUM_W  = 21;

   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = 3;
   localparam int FIFO_CW    = 4;

   typedef struct packed {
      logic [23:0] wt_top;
      logic [23:0] wt_mid;
      logic [23:0] wt_bot;
      logic [12:0] frame_width;
      logic [12:0] frame_height;
      logic [2:0]  channel_count;
   } cfg_type;

   typedef struct packed {
      logic ovalid;
      logic border;
      logic last;
   } item_ctl_type;

   typedef struct packed {
      logic       out_valid;
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_word_type;

endpackage

`default_nettype wire

### hw/rtl/c3ws_if.sv
// channel interfaces: pixel byte input, result output, register writes
`timescale 1ns / 1ps
`default_nettype none

interface c3ws_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_byte;
   logic       frame_start;
   logic       flush;
   modport source (output valid, pixel_byte, frame_start, flush, input ready);
   modport sink (input valid, pixel_byte, frame_start, flush, output ready);
endinterface

interface c3ws_rsp_if;
   logic       valid;
   logic       ready;
   logic       out_valid;
   logic [7:0] out_byte;
   logic       out_last;
   modport source (output valid, out_valid, out_byte, out_last, input ready);
   modport sink (input valid, out_valid, out_byte, out_last, output ready);
endinterface

interface c3ws_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [23:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/c3ws_seq.sv
// position counters, line store address and per-item border/valid decode
`timescale 1ns / 1ps
`default_nettype none

module c3ws_seq #(
   parameter int MAX_ROW_PIXELS = 4096,
   parameter int MAX_CHANNELS   = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  c3ws_pkg::cfg_type      cfg,
   input  logic                   cfg_wr,
   input  logic                   fire,
   input  logic [7:0]             pixel_byte,
   input  logic                   frame_start,
   input  logic                   flush,
   output logic                   busy,
   output logic [2:0]             chan_count,
   output logic                   rd_en,
   output logic [$clog2(MAX_ROW_PIXELS*MAX_CHANNELS)-1:0] rd_idx,
   output logic [7:0]             cur_byte,
   output c3ws_pkg::item_ctl_type ctl
);
   import c3ws_pkg::*;

   localparam int PW = $clog2(MAX_ROW_PIXELS + 1);
   localparam int XW = (PW > 13) ? PW : 13;
   localparam int AW = $clog2(MAX_ROW_PIXELS * MAX_CHANNELS);
   localparam logic [XW-1:0] W_MAX = XW'(MAX_ROW_PIXELS);
   localparam logic [2:0]    C_MAX = 3'(MAX_CHANNELS);

   logic [XW-1:0]      fw_x;
   logic [XW-1:0]      w_x;
   logic [PW-1:0]      w;
   logic [12:0]        h;
   logic [2:0]         c;

   logic [1:0]         settle_ff;
   logic [COUNT_W-1:0] wh_ff;
   logic [COUNT_W-1:0] wh_in;
   logic [COUNT_W-1:0] total_ff;
   logic [COUNT_W-1:0] total_in;

   logic [2:0]         cc_ff, cc_in, cc_s, cc_e, cc_nx;
   logic [PW-1:0]      cp_ff, cp_in, cp_s, cp_e, cp_nx;
   logic [ROW_W-1:0]   row_ff, row_in, row_s, orow;
   logic [COUNT_W-1:0] em_ff, em_in, em_s;
   logic               ovalid;

   // clamped frame geometry
   always_comb begin
      fw_x = XW'(cfg.frame_width);
      if (fw_x < XW'(3)) begin
         w_x = XW'(3);
      end else if (fw_x > W_MAX) begin
         w_x = W_MAX;
      end else begin
         w_x = fw_x;
      end
      w = PW'(w_x);
      if (cfg.frame_height < 13'd3) begin
         h = 13'd3;
      end else if (cfg.frame_height > FRAME_HEIGHT_MAX) begin
         h = FRAME_HEIGHT_MAX;
      end else begin
         h = cfg.frame_height;
      end
      if (cfg.channel_count == 3'd0) begin
         c = 3'd1;
      end else if (cfg.channel_count > C_MAX) begin
         c = C_MAX;
      end else begin
         c = cfg.channel_count;
      end
   end

   assign wh_in    = COUNT_W'(w) * COUNT_W'(h);
   assign total_in = wh_ff * COUNT_W'(c);
   assign busy     = |settle_ff;
   assign chan_count = c;

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= 2'b11;
      end else if (cfg_wr) begin
         settle_ff <= 2'b11;
      end else begin
         settle_ff <= {1'b0, settle_ff[1]};
      end
   end

   always_ff @(posedge clock) begin
      wh_ff    <= wh_in;
      total_ff <= total_in;
   end

   // item decode
   always_comb begin
      cc_s  = frame_start ? '0 : cc_ff;
      cp_s  = frame_start ? '0 : cp_ff;
      row_s = frame_start ? '0 : row_ff;
      em_s  = frame_start ? '0 : em_ff;
      cc_e  = (cc_s >= c) ? c - 3'd1 : cc_s;
      cp_e  = (cp_s >= w) ? w - PW'(1) : cp_s;
      rd_idx = AW'(cp_e) * AW'(c) + AW'(cc_e);
      ovalid = ((row_s >= ROW_W'(2)) || ((row_s == ROW_W'(1)) && (cp_e != '0)))
               && (em_s < total_ff);
      orow = (cp_e == '0) ? row_s - ROW_W'(2) : row_s - ROW_W'(1);
      ctl.ovalid = ovalid;
      ctl.border = (orow == '0) || (orow >= ROW_W'(h) - ROW_W'(1)) || (cp_e <= PW'(1));
      ctl.last   = ovalid && (em_s == total_ff - COUNT_W'(1));
      em_in = em_s + COUNT_W'(ovalid);
      cc_nx = cc_e + 3'd1;
      cp_nx = cp_e + PW'(1);
      if (cc_nx >= c) begin
         cc_in = '0;
         if (cp_nx >= w) begin
            cp_in  = '0;
            row_in = (row_s != ROW_CAP) ? row_s + ROW_W'(1) : row_s;
         end else begin
            cp_in  = cp_nx;
            row_in = row_s;
         end
      end else begin
         cc_in  = cc_nx;
         cp_in  = cp_e;
         row_in = row_s;
      end
   end

   assign rd_en    = fire;
   assign cur_byte = flush ? 8'd0 : pixel_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         cc_ff  <= '0;
         cp_ff  <= '0;
         row_ff <= '0;
         em_ff  <= '0;
      end else if (fire) begin
         cc_ff  <= cc_in;
         cp_ff  <= cp_in;
         row_ff <= row_in;
         em_ff  <= em_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/c3ws_line_store.sv
// two row memories with read-modify-write and same-address forwarding
`timescale 1ns / 1ps
`default_nettype none

module c3ws_line_store #(
   parameter int DEPTH = 16384
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_idx,
   input  logic [7:0]                 cur_byte,
   input  c3ws_pkg::item_ctl_type     ctl,
   output logic                       col_vld,
   output logic [7:0]                 col_up,
   output logic [7:0]                 col_mid,
   output logic [7:0]                 col_cur,
   output c3ws_pkg::item_ctl_type     col_ctl
);
   import c3ws_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic [7:0]    upper_mem [DEPTH];
   logic [7:0]    middle_mem [DEPTH];

   logic [7:0]    up_rd_ff;
   logic [7:0]    mid_rd_ff;
   logic          s1_vld_ff;
   logic [AW-1:0] s1_idx_ff;
   logic [7:0]    s1_cur_ff;
   item_ctl_type  s1_ctl_ff;
   logic          s1_fwd_ff;
   logic          fwd_in;
   logic [7:0]    fwd_up_ff;
   logic [7:0]    fwd_mid_ff;

   // read of an entry written at the same edge sees the old word
   assign fwd_in = rd_en && s1_vld_ff && (rd_idx == s1_idx_ff);

   assign col_vld = s1_vld_ff;
   assign col_up  = s1_fwd_ff ? fwd_up_ff : up_rd_ff;
   assign col_mid = s1_fwd_ff ? fwd_mid_ff : mid_rd_ff;
   assign col_cur = s1_cur_ff;
   assign col_ctl = s1_ctl_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         up_rd_ff <= upper_mem[rd_idx];
      end
      if (s1_vld_ff) begin
         upper_mem[s1_idx_ff] <= col_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mid_rd_ff <= middle_mem[rd_idx];
      end
      if (s1_vld_ff) begin
         middle_mem[s1_idx_ff] <= s1_cur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_idx_ff  <= rd_idx;
         s1_cur_ff  <= cur_byte;
         s1_ctl_ff  <= ctl;
         s1_fwd_ff  <= fwd_in;
         fwd_up_ff  <= col_mid;
         fwd_mid_ff <= s1_cur_ff;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/c3ws_window_mac.sv
// 3x3 window shift register, weight products and saturating sum
`timescale 1ns / 1ps
`default_nettype none

module c3ws_window_mac #(
   parameter int MAX_CHANNELS = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  c3ws_pkg::cfg_type      cfg,
   input  logic [2:0]             chan_count,
   input  logic                   col_vld,
   input  logic [7:0]             col_up,
   input  logic [7:0]             col_mid,
   input  logic [7:0]             col_cur,
   input  c3ws_pkg::item_ctl_type col_ctl,
   output logic                   push,
   output c3ws_pkg::rsp_word_type word
);
   import c3ws_pkg::*;

   localparam int WC = 2 * MAX_CHANNELS + 1;
   localparam int TW = $clog2(WC);

   logic [7:0]              win_ff [WC][3];
   logic                    s2_vld_ff;
   item_ctl_type            s2_ctl_ff;
   logic                    s3_vld_ff;
   item_ctl_type            s3_ctl_ff;
   logic signed [PROD_W-1:0] prod_in [9];
   logic signed [PROD_W-1:0] prod_ff [9];
   logic [23:0]             wrow [3];
   logic [TW-1:0]           tap [3];
   logic signed [7:0]       wt_s;
   logic signed [8:0]       bv_s;
   logic signed [SUM_W-1:0] sum;

   assign wrow[0] = cfg.wt_top;
   assign wrow[1] = cfg.wt_mid;
   assign wrow[2] = cfg.wt_bot;
   assign tap[0]  = TW'({chan_count, 1'b0});
   assign tap[1]  = TW'(chan_count);
   assign tap[2]  = '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WC; i++) begin
            for (int r = 0; r < 3; r++) begin
               win_ff[i][r] <= 8'd0;
            end
         end
      end else if (col_vld) begin
         for (int i = WC - 1; i > 0; i--) begin
            for (int r = 0; r < 3; r++) begin
               win_ff[i][r] <= win_ff[i-1][r];
            end
         end
         win_ff[0][0] <= col_up;
         win_ff[0][1] <= col_mid;
         win_ff[0][2] <= col_cur;
      end
   end

   always_comb begin
      wt_s = '0;
      bv_s = '0;
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            wt_s = $signed(wrow[r][8*k +: 8]);
            bv_s = $signed({1'b0, win_ff[tap[k]][r]});
            prod_in[3*r+k] = PROD_W'(wt_s) * PROD_W'(bv_s);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= col_vld;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_ctl_ff <= col_ctl;
      s3_ctl_ff <= s2_ctl_ff;
      for (int i = 0; i < 9; i++) begin
         prod_ff[i] <= prod_in[i];
      end
   end

   always_comb begin
      sum = '0;
      for (int i = 0; i < 9; i++) begin
         sum = sum + SUM_W'(prod_ff[i]);
      end
      word.out_valid = s3_ctl_ff.ovalid;
      word.out_last  = s3_ctl_ff.ovalid && s3_ctl_ff.last;
      if (!s3_ctl_ff.ovalid || s3_ctl_ff.border || (sum < 0)) begin
         word.out_byte = 8'd0;
      end else if (sum > SUM_W'(255)) begin
         word.out_byte = 8'd255;
      end else begin
         word.out_byte = sum[7:0];
      end
   end

   assign push = s3_vld_ff;

endmodule

`default_nettype wire

### hw/rtl/c3ws_rsp_fifo.sv
// result queue with outstanding-transaction credit for the input side
`timescale 1ns / 1ps
`default_nettype none

module c3ws_rsp_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   push,
   input  c3ws_pkg::rsp_word_type word,
   output logic                   room,
   c3ws_rsp_if.source             rsp_if
);
   import c3ws_pkg::*;

   rsp_word_type       mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff;
   logic [FIFO_AW-1:0] rd_ptr_ff;
   logic [FIFO_CW-1:0] fill_ff;
   logic [FIFO_CW-1:0] fill_in;
   logic [FIFO_CW-1:0] outst_ff;
   logic [FIFO_CW-1:0] outst_in;
   logic               pop;
   rsp_word_type       head;

   assign head             = mem_ff[rd_ptr_ff];
   assign rsp_if.valid     = (fill_ff != '0);
   assign rsp_if.out_valid = head.out_valid;
   assign rsp_if.out_byte  = head.out_byte;
   assign rsp_if.out_last  = head.out_last;
   assign pop              = rsp_if.valid && rsp_if.ready;
   assign room             = (outst_ff < FIFO_CW'(FIFO_DEPTH));

   always_comb begin
      case ({push, pop})
         2'b10:   fill_in = fill_ff + FIFO_CW'(1);
         2'b01:   fill_in = fill_ff - FIFO_CW'(1);
         default: fill_in = fill_ff;
      endcase
      case ({accept, pop})
         2'b10:   outst_in = outst_ff + FIFO_CW'(1);
         2'b01:   outst_in = outst_ff - FIFO_CW'(1);
         default: outst_in = outst_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         outst_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(1);
         end
         fill_ff  <= fill_in;
         outst_ff <= outst_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/conv3x3_weighted_saturating_unit.sv
// top level of the streaming 3x3 weighted saturating convolution
`timescale 1ns / 1ps
`default_nettype none

// Takes one interleaved channel byte per clock while ready is high, and
// returns exactly one result transaction per input transaction, in order, at
// a sustained rate of one per cycle while results are taken. A byte's result
// passes the registered steps line store read, window shift and the nine
// weight products, then the sum and clamp to 0..255, into the result queue.
// The two row buffers are single memories of MAX_ROW_PIXELS*MAX_CHANNELS
// bytes, each doing one read and one write per cycle; they are not cleared
// after reset. Up to eight transactions may be outstanding, so the input
// keeps flowing while results wait to be taken. After any register write the
// input holds ready low while the frame byte count settles. The filtered
// value of a byte lags its input by one row plus one pixel; send flush
// transactions to drain the final row.
module conv3x3_weighted_saturating_unit #(
   parameter int MAX_ROW_PIXELS = 4096,
   parameter int MAX_CHANNELS   = 4
) (
   input  logic       clock,
   input  logic       reset,
   c3ws_req_if.sink   req_if,
   c3ws_rsp_if.source rsp_if,
   c3ws_csr_if.sink   csr_if
);
   import c3ws_pkg::*;

   localparam int LD = MAX_ROW_PIXELS * MAX_CHANNELS;
   localparam int AW = $clog2(LD);

   cfg_type       cfg_ff;
   logic          csr_fire;
   logic          req_fire;
   logic          busy;
   logic          room;
   logic [2:0]    chan_count;
   logic          rd_en;
   logic [AW-1:0] rd_idx;
   logic [7:0]    cur_byte;
   item_ctl_type  ctl;
   logic          col_vld;
   logic [7:0]    col_up;
   logic [7:0]    col_mid;
   logic [7:0]    col_cur;
   item_ctl_type  col_ctl;
   logic          push;
   rsp_word_type  word;

   assign csr_if.ready = 1'b1;
   assign csr_fire     = csr_if.valid && csr_if.ready;
   assign req_if.ready = room && !busy;
   assign req_fire     = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wt_top        <= '0;
         cfg_ff.wt_mid        <= '0;
         cfg_ff.wt_bot        <= '0;
         cfg_ff.frame_width   <= FRAME_WIDTH_RST;
         cfg_ff.frame_height  <= FRAME_HEIGHT_RST;
         cfg_ff.channel_count <= CHANNEL_COUNT_RST;
      end else if (csr_fire) begin
         case (csr_if.index)
            CSR_WEIGHTS_TOP:    cfg_ff.wt_top        <= csr_if.data;
            CSR_WEIGHTS_MIDDLE: cfg_ff.wt_mid        <= csr_if.data;
            CSR_WEIGHTS_BOTTOM: cfg_ff.wt_bot        <= csr_if.data;
            CSR_FRAME_WIDTH:    cfg_ff.frame_width   <= csr_if.data[12:0];
            CSR_FRAME_HEIGHT:   cfg_ff.frame_height  <= csr_if.data[12:0];
            CSR_CHANNEL_COUNT:  cfg_ff.channel_count <= csr_if.data[2:0];
            default: begin
            end
         endcase
      end
   end

   c3ws_seq #(
      .MAX_ROW_PIXELS (MAX_ROW_PIXELS),
      .MAX_CHANNELS   (MAX_CHANNELS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .cfg_wr      (csr_fire),
      .fire        (req_fire),
      .pixel_byte  (req_if.pixel_byte),
      .frame_start (req_if.frame_start),
      .flush       (req_if.flush),
      .busy        (busy),
      .chan_count  (chan_count),
      .rd_en       (rd_en),
      .rd_idx      (rd_idx),
      .cur_byte    (cur_byte),
      .ctl         (ctl)
   );

   c3ws_line_store #(
      .DEPTH (LD)
   ) u_line_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_idx   (rd_idx),
      .cur_byte (cur_byte),
      .ctl      (ctl),
      .col_vld  (col_vld),
      .col_up   (col_up),
      .col_mid  (col_mid),
      .col_cur  (col_cur),
      .col_ctl  (col_ctl)
   );

   c3ws_window_mac #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_window_mac (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .chan_count (chan_count),
      .col_vld    (col_vld),
      .col_up     (col_up),
      .col_mid    (col_mid),
      .col_cur    (col_cur),
      .col_ctl    (col_ctl),
      .push       (push),
      .word       (word)
   );

   c3ws_rsp_fifo u_rsp_fifo (
      .clock  (clock),
      .reset  (reset),
      .accept (req_fire),
      .push   (push),
      .word   (word),
      .room   (room),
      .rsp_if (rsp_if)
   );

endmodule

`default_nettype wire
